>>> rtl/core/mmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmt_pkg;

  // Bitmap row geometry: one memory word holds this many presence bits.
  localparam int unsigned ROW_W   = 64;
  localparam int unsigned BIT_W   = 6;

  // Fixed field widths of the channels.
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned MEX_W   = 11;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [MEX_W-1:0]          mex_t;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

>>> rtl/core/mmt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mmt_in_if
  import mmt_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   cmd;
  value_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mmt_out_if
  import mmt_pkg::*;
();
  logic valid;
  logic ready;
  mex_t mex;
  logic ignored;
  logic mex_saturated;

  modport source (output valid, output mex, output ignored, output mex_saturated,
                  input ready);
  modport sink   (input valid, input mex, input ignored, input mex_saturated,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/multiset_mex_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none

// An item passes UPDATE, LOOKUP and RESULT into the output register, waiting in
// RESULT while out_o holds an untaken result; in_i.ready is high only in IDLE, so
// items go one at a time (count/bitmap read, write-back, row lookup, first-zero
// pick). The bitmap memory has a single read port. Reset: asynchronous, active
// low; a clearing pass then zeroes all ceil(VALUES/64) rows while in_i.ready is low.
module multiset_mex_tracker_core
  import mmt_pkg::*;
#(
  parameter int unsigned VALUES     = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  mmt_in_if.sink     in_i,
  mmt_out_if.source  out_o
);

  localparam int unsigned IDX_W  = $clog2(VALUES);
  localparam int unsigned ROWS   = (VALUES + ROW_W - 1) / ROW_W;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_LOOKUP,
    ST_RESULT
  } state_e;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ROW_W-1:0]      row_t;

  // Mark bits of a row that lie at or above VALUES; they count as present so
  // that a padded last row can still read as full.
  function automatic row_t pad_mask(input logic [ROW_AW-1:0] r);
    row_t        pad;
    logic [31:0] base;
    base = 32'(r) << BIT_W;
    for (int b = 0; b < ROW_W; b++) begin
      pad[b] = (base + 32'(b)) >= 32'(VALUES);
    end
    return pad;
  endfunction

  // Lowest clear bit of a row word.
  function automatic logic [BIT_W-1:0] first_zero(input row_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!w[b]) pos = BIT_W'(b);
    end
    return pos;
  endfunction

  // ---------------------------------------------------------------------------
  // State and item registers
  // ---------------------------------------------------------------------------
  state_e            state_q;
  logic [ROW_AW-1:0] clr_q;
  logic [ROWS-1:0]   full_q;       // one flag per bitmap row: every bit set
  logic              cmd_q;
  logic              ok_q;         // value lies in 0..VALUES-1
  logic [IDX_W-1:0]  idx_q;
  logic [ROW_AW-1:0] row_q;
  logic [BIT_W-1:0]  bit_q;
  logic              ignored_q;
  logic              found_q;      // some row is not full
  logic [ROW_AW-1:0] lrow_q;
  logic              out_valid_q;
  mex_t              out_mex_q;
  logic              out_ign_q;
  logic              out_sat_q;

  // ---------------------------------------------------------------------------
  // Memories: copy counts (one per value) and presence bitmap (one row per 64)
  // A count is only trusted while its presence bit is set, so the count memory
  // needs no clearing; the bitmap is swept to zero after reset.
  // ---------------------------------------------------------------------------
  count_t count_mem [VALUES];
  row_t   row_mem   [ROWS];
  count_t count_rd_q;
  row_t   row_rd_q;

  logic [IDX_W-1:0]  cnt_ra;
  logic              cnt_we;
  count_t            cnt_wd;
  logic [ROW_AW-1:0] row_ra;
  logic              row_we;
  logic [ROW_AW-1:0] row_wa;
  row_t              row_wd;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic [31:0]       in_val32;
  logic              in_ok;
  logic [IDX_W-1:0]  in_idx;
  logic [31:0]       in_idx32;
  logic [31:0]       in_row32;

  assign in_val32 = 32'(in_i.value[VALUE_W-2:0]);
  assign in_ok    = !in_i.value[VALUE_W-1] && (in_val32 < 32'(VALUES));
  assign in_idx   = in_ok ? in_val32[IDX_W-1:0] : '0;   // keep reads inside the memory
  assign in_idx32 = 32'(in_idx);
  assign in_row32 = in_idx32 >> BIT_W;

  assign in_i.ready = (state_q == ST_IDLE);

  // ---------------------------------------------------------------------------
  // Read-modify-write of the addressed count and bitmap row
  // ---------------------------------------------------------------------------
  logic   present;
  count_t cnt_cur;
  logic   upd_do;
  count_t cnt_new;
  row_t   row_new;
  logic   row_full_new;

  always_comb begin
    present = row_rd_q[bit_q];
    cnt_cur = present ? count_rd_q : '0;
    if (cmd_q == CMD_REMOVE) begin
      upd_do  = ok_q && (cnt_cur != '0);
      cnt_new = cnt_cur - COUNT_BITS'(1);
    end else begin
      upd_do  = ok_q && (cnt_cur != '1);
      cnt_new = cnt_cur + COUNT_BITS'(1);
    end
    row_new        = row_rd_q;
    row_new[bit_q] = (cnt_new != '0);
    row_full_new   = &(row_new | pad_mask(row_q));
  end

  // ---------------------------------------------------------------------------
  // Lowest row that is not full
  // ---------------------------------------------------------------------------
  logic              lk_found;
  logic [ROW_AW-1:0] lk_row;

  always_comb begin
    lk_found = 1'b0;
    lk_row   = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!full_q[r]) begin
        lk_found = 1'b1;
        lk_row   = ROW_AW'(r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Memory port steering
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_ra = in_idx;
    // hold the looked-up row on the read port while the result waits
    row_ra = (state_q == ST_LOOKUP) ? lk_row
           : (state_q == ST_RESULT) ? lrow_q : in_row32[ROW_AW-1:0];
    cnt_we = (state_q == ST_UPDATE) && upd_do;
    cnt_wd = cnt_new;
    row_we = 1'b0;
    row_wa = row_q;
    row_wd = row_new;
    unique case (state_q)
      ST_CLEAR: begin
        row_we = 1'b1;
        row_wa = clr_q;
        row_wd = '0;
      end
      ST_UPDATE: row_we = upd_do;
      default:   row_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) count_mem[idx_q] <= cnt_wd;
    count_rd_q <= count_mem[cnt_ra];
  end

  // The write-back lands in the cycle before the lookup read, so the same row is
  // never read and written in the same cycle by the same item.
  always_ff @(posedge clk_i) begin
    if (row_we) row_mem[row_wa] <= row_wd;
    row_rd_q <= row_mem[row_ra];
  end

  // ---------------------------------------------------------------------------
  // Result word
  // ---------------------------------------------------------------------------
  logic [31:0] mex32;

  assign mex32 = found_q
               ? ((32'(lrow_q) << BIT_W) | 32'(first_zero(row_rd_q | pad_mask(lrow_q))))
               : 32'(VALUES);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      full_q      <= '0;
      cmd_q       <= 1'b0;
      ok_q        <= 1'b0;
      idx_q       <= '0;
      row_q       <= '0;
      bit_q       <= '0;
      ignored_q   <= 1'b0;
      found_q     <= 1'b0;
      lrow_q      <= '0;
      out_valid_q <= 1'b0;
      out_mex_q   <= '0;
      out_ign_q   <= 1'b0;
      out_sat_q   <= 1'b0;
    end else begin
      // drop the result once it has been taken, unless a new one replaces it
      if (out_valid_q && out_o.ready && state_q != ST_RESULT) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ROW_AW'(1);
          if (clr_q == ROW_AW'(ROWS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            cmd_q   <= in_i.cmd;
            ok_q    <= in_ok;
            idx_q   <= in_idx;
            row_q   <= in_row32[ROW_AW-1:0];
            bit_q   <= in_idx32[BIT_W-1:0];
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          ignored_q <= !upd_do;
          if (upd_do) full_q[row_q] <= row_full_new;
          state_q   <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          found_q <= lk_found;
          lrow_q  <= lk_row;
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_mex_q   <= mex32[MEX_W-1:0];
            out_ign_q   <= ignored_q;
            out_sat_q   <= !found_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.mex           = out_mex_q;
  assign out_o.ignored       = out_ign_q;
  assign out_o.mex_saturated = out_sat_q;

endmodule

`default_nettype wire
